/* hw/rtl/psched_pkg.sv */
`default_nettype none
package psched_pkg;

    localparam int MAX_JOBS       = 16;
    localparam int NUM_PRIORITIES = 4;
    localparam int DELAY_BITS     = 16;

    localparam int ID_W       = $clog2(MAX_JOBS);
    localparam int PRIO_W     = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
    localparam int CNT_W      = $clog2(MAX_JOBS + 1);
    localparam int NUM_LISTS  = NUM_PRIORITIES + 1;
    localparam int LIST_W     = $clog2(NUM_LISTS);
    localparam int SLEEP_LIST = NUM_PRIORITIES;
    localparam int LADDR_W    = LIST_W + ID_W;
    localparam int LIST_DEPTH = NUM_LISTS * MAX_JOBS;
    localparam int SUM_W      = CNT_W + LIST_W;

    typedef enum logic [2:0] {
        ACT_ATTACH   = 3'd0,
        ACT_STOP     = 3'd1,
        ACT_SUSPEND  = 3'd2,
        ACT_ACTIVATE = 3'd3,
        ACT_SET_PRIO = 3'd4,
        ACT_RUN      = 3'd5,
        ACT_TICK     = 3'd6,
        ACT_QUERY    = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        MODE_UNINIT    = 2'd0,
        MODE_ACTIVE    = 2'd1,
        MODE_SUSPENDED = 2'd2,
        MODE_SLEEPING  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_IGNORED = 2'd1,
        STAT_EMPTY   = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_JCHK,
        S_DRD,
        S_DWR,
        S_APP,
        S_RJRD,
        S_RJWR,
        S_TRD,
        S_TJ,
        S_TW,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]        action;
        logic [3:0]        job_id;
        logic signed [7:0] job_priority;
        logic [1:0]        job_state;
        logic [15:0]       job_period;
        logic [15:0]       start_delay;
    } t_cmd;

    typedef struct packed {
        logic [3:0] dispatched_job;
        logic       dispatch_valid;
        logic [4:0] job_count;
        logic [1:0] status;
    } t_result;

    typedef struct packed {
        t_mode                 mode;
        logic [PRIO_W-1:0]     prio;
        logic [DELAY_BITS-1:0] period;
        logic [DELAY_BITS-1:0] delay;
    } t_job;

    typedef struct packed {
        logic            we;
        logic [ID_W-1:0] waddr;
        t_job            wdata;
        logic [ID_W-1:0] raddr;
    } t_job_port;

    typedef struct packed {
        logic               we;
        logic [LADDR_W-1:0] waddr;
        logic [ID_W-1:0]    wdata;
        logic [LADDR_W-1:0] raddr;
    } t_list_port;

    function automatic logic [PRIO_W-1:0] clamp_prio(input logic signed [7:0] v);
        logic [PRIO_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (int'(v) > NUM_PRIORITIES - 1) begin
            res = PRIO_W'(NUM_PRIORITIES - 1);
        end else begin
            res = v[PRIO_W-1:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/psched_job_mem.sv */
`default_nettype none
module psched_job_mem (
    input  wire logic                  i_clk,
    input  wire psched_pkg::t_job_port i_port,
    output psched_pkg::t_job           o_rdata
);

    psched_pkg::t_job mem [psched_pkg::MAX_JOBS];

    // write one entry, read one entry through a registered output
    always_ff @(posedge i_clk) begin
        if (i_port.we) begin
            mem[i_port.waddr] <= i_port.wdata;
        end
        o_rdata <= mem[i_port.raddr];
    end

endmodule
`default_nettype wire

/* hw/rtl/psched_list_mem.sv */
`default_nettype none
module psched_list_mem (
    input  wire logic                         i_clk,
    input  wire psched_pkg::t_list_port       i_port,
    output logic [psched_pkg::ID_W-1:0]       o_rdata
);

    // one ring of MAX_JOBS slots per ready priority, plus the sleep list
    logic [psched_pkg::ID_W-1:0] mem [psched_pkg::LIST_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_port.we) begin
            mem[i_port.waddr] <= i_port.wdata;
        end
        o_rdata <= mem[i_port.raddr];
    end

endmodule
`default_nettype wire

/* hw/rtl/priority_job_scheduler.sv */
`default_nettype none
// Fixed-priority job scheduler.
// Command channel: i_cmd is taken at a rising edge with start high and busy
// low. Every command gives exactly one result on o_result, shown for one
// cycle with o_done high; the receiver takes it at the end of that cycle
// and cannot hold it off. busy stays high from acceptance to that cycle.
// Job fields sit in a 16-entry job memory, the ready rings and the sleep
// list in one list memory; both have one read and one write port and a
// registered read, and every step reads, modifies and writes back in turn.
// Steps per command: an ignored command or a count query goes straight
// to its result; run pops the head of the highest non-empty ready ring,
// rewrites that job and puts it on the sleep list or suspends it, and
// reports empty when no ring holds a job; attach, stop, suspend, activate
// and set priority rewrite the job entry, walk the list the job leaves if
// it is in one, and append it to the list it joins; tick walks the sleep list.
// Reset empties all lists, detaches every job and clears the count; no
// clearing pass is needed, so a command may start right after reset.
module priority_job_scheduler (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    input  wire psched_pkg::t_cmd    i_cmd,
    output logic                     busy,
    output logic                     o_done,
    output psched_pkg::t_result      o_result
);

    localparam int ID_W    = psched_pkg::ID_W;
    localparam int CNT_W   = psched_pkg::CNT_W;
    localparam int LIST_W  = psched_pkg::LIST_W;
    localparam int PRIO_W  = psched_pkg::PRIO_W;
    localparam int NLISTS  = psched_pkg::NUM_LISTS;
    localparam int NJOBS   = psched_pkg::MAX_JOBS;
    localparam int SUM_W_L = psched_pkg::SUM_W;
    localparam logic [LIST_W-1:0] SLEEP = LIST_W'(psched_pkg::SLEEP_LIST);

    psched_pkg::t_state  r_state, n_state;
    psched_pkg::t_cmd    r_cmd, n_cmd;
    logic [NJOBS-1:0]    r_attached, n_attached;
    logic [CNT_W-1:0]    r_total, n_total;
    logic [ID_W-1:0]     r_head [NLISTS];
    logic [ID_W-1:0]     n_head [NLISTS];
    logic [CNT_W-1:0]    r_fill [NLISTS];
    logic [CNT_W-1:0]    n_fill [NLISTS];
    logic [CNT_W-1:0]    r_rd, n_rd;
    logic [CNT_W-1:0]    r_wr, n_wr;
    logic [LIST_W-1:0]   r_list, n_list;
    logic                r_app_en, n_app_en;
    logic [LIST_W-1:0]   r_app_list, n_app_list;
    logic [ID_W-1:0]     r_id, n_id;
    logic [ID_W-1:0]     r_disp, n_disp;
    logic                r_valid, n_valid;
    psched_pkg::t_status r_status, n_status;

    psched_pkg::t_job_port  job_port;
    psched_pkg::t_job       job_rdata;
    psched_pkg::t_list_port list_port;
    logic [ID_W-1:0]        list_rdata;

    logic                   any_ready;
    logic [PRIO_W-1:0]      top_prio;
    logic [ID_W-1:0]        slot;
    logic [LIST_W-1:0]      tick_list;
    psched_pkg::t_job       upd;
    logic [SUM_W_L-1:0]     fill_sum;

    psched_job_mem u_job_mem (
        .i_clk   (i_clk),
        .i_port  (job_port),
        .o_rdata (job_rdata)
    );

    psched_list_mem u_list_mem (
        .i_clk   (i_clk),
        .i_port  (list_port),
        .o_rdata (list_rdata)
    );

    // pick the highest non-empty ready ring
    always_comb begin
        any_ready = 1'b0;
        top_prio  = '0;
        for (int p = 0; p < psched_pkg::NUM_PRIORITIES; p++) begin
            if (r_fill[p] != '0) begin
                any_ready = 1'b1;
                top_prio  = PRIO_W'(p);
            end
        end
    end

    // hold state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= psched_pkg::S_IDLE;
            r_attached <= '0;
            r_total    <= '0;
            for (int l = 0; l < NLISTS; l++) begin
                r_head[l] <= '0;
                r_fill[l] <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_attached <= n_attached;
            r_total    <= n_total;
            for (int l = 0; l < NLISTS; l++) begin
                r_head[l] <= n_head[l];
                r_fill[l] <= n_fill[l];
            end
        end
    end

    // hold working registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_rd       <= n_rd;
        r_wr       <= n_wr;
        r_list     <= n_list;
        r_app_en   <= n_app_en;
        r_app_list <= n_app_list;
        r_id       <= n_id;
        r_disp     <= n_disp;
        r_valid    <= n_valid;
        r_status   <= n_status;
    end

    // sequence commands over the two memories
    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_attached = r_attached;
        n_total    = r_total;
        n_head     = r_head;
        n_fill     = r_fill;
        n_rd       = r_rd;
        n_wr       = r_wr;
        n_list     = r_list;
        n_app_en   = r_app_en;
        n_app_list = r_app_list;
        n_id       = r_id;
        n_disp     = r_disp;
        n_valid    = r_valid;
        n_status   = r_status;
        job_port   = '0;
        list_port  = '0;
        slot       = '0;
        tick_list  = '0;
        upd        = job_rdata;
        job_port.raddr = r_id;

        case (r_state)
            psched_pkg::S_IDLE: begin
                if (start) begin
                    n_cmd    = i_cmd;
                    n_id     = i_cmd.job_id;
                    n_disp   = '0;
                    n_valid  = 1'b0;
                    n_status = psched_pkg::STAT_DONE;
                    n_rd     = '0;
                    n_wr     = '0;
                    job_port.raddr = i_cmd.job_id;
                    case (psched_pkg::t_action'(i_cmd.action))
                        psched_pkg::ACT_ATTACH: begin
                            if (i_cmd.job_state == psched_pkg::MODE_UNINIT) begin
                                n_status = psched_pkg::STAT_IGNORED;
                                n_state  = psched_pkg::S_DONE;
                            end else begin
                                n_state = psched_pkg::S_JCHK;
                            end
                        end
                        psched_pkg::ACT_STOP, psched_pkg::ACT_SUSPEND,
                        psched_pkg::ACT_ACTIVATE, psched_pkg::ACT_SET_PRIO: begin
                            if (!r_attached[i_cmd.job_id]) begin
                                n_status = psched_pkg::STAT_IGNORED;
                                n_state  = psched_pkg::S_DONE;
                            end else begin
                                n_state = psched_pkg::S_JCHK;
                            end
                        end
                        psched_pkg::ACT_RUN: begin
                            if (any_ready) begin
                                n_list = LIST_W'(top_prio);
                                list_port.raddr = {LIST_W'(top_prio),
                                                   r_head[LIST_W'(top_prio)]};
                                n_state = psched_pkg::S_RJRD;
                            end else begin
                                n_status = psched_pkg::STAT_EMPTY;
                                n_state  = psched_pkg::S_DONE;
                            end
                        end
                        psched_pkg::ACT_TICK: begin
                            n_state = psched_pkg::S_TRD;
                        end
                        default: begin
                            n_state = psched_pkg::S_DONE;
                        end
                    endcase
                end
            end

            // old entry is here: update it, pick the list to leave and join
            psched_pkg::S_JCHK: begin
                n_app_en   = 1'b0;
                n_app_list = SLEEP;
                case (psched_pkg::t_action'(r_cmd.action))
                    psched_pkg::ACT_ATTACH: begin
                        upd.mode   = psched_pkg::t_mode'(r_cmd.job_state);
                        upd.prio   = psched_pkg::clamp_prio(r_cmd.job_priority);
                        upd.period = psched_pkg::DELAY_BITS'(r_cmd.job_period);
                        upd.delay  = psched_pkg::DELAY_BITS'(r_cmd.start_delay);
                        if (!r_attached[r_id]) begin
                            n_attached[r_id] = 1'b1;
                            n_total          = r_total + 1'b1;
                        end
                    end
                    psched_pkg::ACT_STOP: begin
                        upd.mode         = psched_pkg::MODE_SUSPENDED;
                        n_attached[r_id] = 1'b0;
                        n_total          = r_total - 1'b1;
                    end
                    psched_pkg::ACT_SUSPEND: begin
                        upd.mode = psched_pkg::MODE_SUSPENDED;
                    end
                    psched_pkg::ACT_ACTIVATE: begin
                        upd.mode = psched_pkg::MODE_ACTIVE;
                    end
                    default: begin
                        upd.prio = psched_pkg::clamp_prio(r_cmd.job_priority);
                    end
                endcase
                job_port.we    = 1'b1;
                job_port.waddr = r_id;
                job_port.wdata = upd;
                if (upd.mode == psched_pkg::MODE_ACTIVE) begin
                    n_app_en   = 1'b1;
                    n_app_list = LIST_W'(upd.prio);
                end else if (upd.mode == psched_pkg::MODE_SLEEPING) begin
                    n_app_en = 1'b1;
                end
                n_state = psched_pkg::S_APP;
                if (r_attached[r_id]) begin
                    if (job_rdata.mode == psched_pkg::MODE_ACTIVE) begin
                        n_list  = LIST_W'(job_rdata.prio);
                        n_state = psched_pkg::S_DRD;
                    end else if (job_rdata.mode == psched_pkg::MODE_SLEEPING) begin
                        n_list  = SLEEP;
                        n_state = psched_pkg::S_DRD;
                    end
                end
            end

            // walk the old list, reading one slot
            psched_pkg::S_DRD: begin
                if (r_rd == r_fill[r_list]) begin
                    n_fill[r_list] = r_wr;
                    n_state        = psched_pkg::S_APP;
                end else begin
                    slot            = r_head[r_list] + r_rd[ID_W-1:0];
                    list_port.raddr = {r_list, slot};
                    n_state         = psched_pkg::S_DWR;
                end
            end

            // keep every other job, compacted toward the head
            psched_pkg::S_DWR: begin
                if (list_rdata != r_id) begin
                    slot            = r_head[r_list] + r_wr[ID_W-1:0];
                    list_port.we    = 1'b1;
                    list_port.waddr = {r_list, slot};
                    list_port.wdata = list_rdata;
                    n_wr            = r_wr + 1'b1;
                end
                n_rd    = r_rd + 1'b1;
                n_state = psched_pkg::S_DRD;
            end

            // append the job at the back of its new list
            psched_pkg::S_APP: begin
                if (r_app_en) begin
                    slot = r_head[r_app_list] + r_fill[r_app_list][ID_W-1:0];
                    list_port.we          = 1'b1;
                    list_port.waddr       = {r_app_list, slot};
                    list_port.wdata       = r_id;
                    n_fill[r_app_list]    = r_fill[r_app_list] + 1'b1;
                end
                n_state = psched_pkg::S_DONE;
            end

            // pop the head of the chosen ring
            psched_pkg::S_RJRD: begin
                n_id           = list_rdata;
                n_disp         = list_rdata;
                n_valid        = 1'b1;
                n_head[r_list] = r_head[r_list] + 1'b1;
                n_fill[r_list] = r_fill[r_list] - 1'b1;
                job_port.raddr = list_rdata;
                n_state        = psched_pkg::S_RJWR;
            end

            // send the dispatched job to sleep, or suspend a one-shot job
            psched_pkg::S_RJWR: begin
                n_app_list = SLEEP;
                if (job_rdata.period == '0) begin
                    upd.mode = psched_pkg::MODE_SUSPENDED;
                    n_app_en = 1'b0;
                end else begin
                    upd.mode  = psched_pkg::MODE_SLEEPING;
                    upd.delay = job_rdata.period;
                    n_app_en  = 1'b1;
                end
                job_port.we    = 1'b1;
                job_port.waddr = r_id;
                job_port.wdata = upd;
                n_state        = psched_pkg::S_APP;
            end

            // tick: read the next sleeper
            psched_pkg::S_TRD: begin
                if (r_rd == r_fill[SLEEP]) begin
                    n_fill[SLEEP] = r_wr;
                    n_state       = psched_pkg::S_DONE;
                end else begin
                    slot            = r_head[SLEEP] + r_rd[ID_W-1:0];
                    list_port.raddr = {SLEEP, slot};
                    n_state         = psched_pkg::S_TJ;
                end
            end

            psched_pkg::S_TJ: begin
                n_id           = list_rdata;
                job_port.raddr = list_rdata;
                n_state        = psched_pkg::S_TW;
            end

            // wake an expired sleeper or count its delay down
            psched_pkg::S_TW: begin
                job_port.we    = 1'b1;
                job_port.waddr = r_id;
                list_port.we   = 1'b1;
                list_port.wdata = r_id;
                if (job_rdata.delay == '0) begin
                    upd.mode  = psched_pkg::MODE_ACTIVE;
                    tick_list = LIST_W'(job_rdata.prio);
                    slot      = r_head[tick_list] + r_fill[tick_list][ID_W-1:0];
                    n_fill[tick_list] = r_fill[tick_list] + 1'b1;
                end else begin
                    upd.delay = job_rdata.delay - 1'b1;
                    tick_list = SLEEP;
                    slot      = r_head[SLEEP] + r_wr[ID_W-1:0];
                    n_wr      = r_wr + 1'b1;
                end
                list_port.waddr = {tick_list, slot};
                job_port.wdata  = upd;
                n_rd            = r_rd + 1'b1;
                n_state         = psched_pkg::S_TRD;
            end

            psched_pkg::S_DONE: begin
                n_state = psched_pkg::S_IDLE;
            end

            default: begin
                n_state = psched_pkg::S_IDLE;
            end
        endcase
    end

    // drive the result
    assign busy   = (r_state != psched_pkg::S_IDLE);
    assign o_done = (r_state == psched_pkg::S_DONE);
    always_comb begin
        o_result.dispatched_job = r_disp;
        o_result.dispatch_valid = r_valid;
        o_result.job_count      = r_total;
        o_result.status         = r_status;
    end

    // total list occupancy, for checking
    always_comb begin
        fill_sum = '0;
        for (int l = 0; l < NLISTS; l++) begin
            fill_sum = fill_sum + SUM_W_L'(r_fill[l]);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_attached) == int'(r_total))
        else $error("job count differs from attached jobs");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psched_pkg::S_IDLE) |-> (fill_sum <= SUM_W_L'(r_total)))
        else $error("more listed jobs than attached jobs");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item left the block idle");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.dispatch_valid) |->
        (o_result.status == psched_pkg::STAT_DONE))
        else $error("dispatch reported with a failing status");

endmodule
`default_nettype wire

/* tb/testbench.sv */
`default_nettype none
module testbench;

    // Predicts scheduler responses and checks them against the block
    class sched_scoreboard;
        bit                    attached [psched_pkg::MAX_JOBS];
        psched_pkg::t_mode     mode_of [psched_pkg::MAX_JOBS];
        logic [1:0]            prio_of [psched_pkg::MAX_JOBS];
        logic [15:0]           period_of [psched_pkg::MAX_JOBS];
        logic [15:0]           delay_of [psched_pkg::MAX_JOBS];
        logic [3:0]            ready_q [psched_pkg::NUM_PRIORITIES][$];
        logic [3:0]            sleep_q [$];
        int                    total;
        psched_pkg::t_result   pending [$];
        int                    errors;
        int                    checked;
        int                    dispatches;

        function new();
            for (int i = 0; i < psched_pkg::MAX_JOBS; i++) begin
                attached[i] = 0;
                mode_of[i] = psched_pkg::MODE_UNINIT;
            end
            total = 0;
            errors = 0;
            checked = 0;
            dispatches = 0;
        endfunction

        function logic [1:0] clip_prio(logic [7:0] raw);
            int v;
            v = $signed(raw);
            if (v < 0) return 2'd0;
            if (v > psched_pkg::NUM_PRIORITIES - 1)
                return 2'(psched_pkg::NUM_PRIORITIES - 1);
            return v[1:0];
        endfunction

        // Take a job out of every ready ring and the sleep list
        function void unlink(int id);
            for (int p = 0; p < psched_pkg::NUM_PRIORITIES; p++)
                for (int k = ready_q[p].size() - 1; k >= 0; k--)
                    if (ready_q[p][k] == id) ready_q[p].delete(k);
            for (int k = sleep_q.size() - 1; k >= 0; k--)
                if (sleep_q[k] == id) sleep_q.delete(k);
        endfunction

        function void relink(int id);
            unlink(id);
            if (mode_of[id] == psched_pkg::MODE_ACTIVE)
                ready_q[prio_of[id]].push_back(4'(id));
            else if (mode_of[id] == psched_pkg::MODE_SLEEPING)
                sleep_q.push_back(4'(id));
        endfunction

        // Advance the model by one accepted item and queue its response
        function void note_item(psched_pkg::t_cmd c);
            psched_pkg::t_result r;
            psched_pkg::t_action a;
            int id;
            logic [3:0] kept [$];
            logic [3:0] j;
            id = c.job_id;
            a = psched_pkg::t_action'(c.action);
            r = '0;
            r.status = psched_pkg::STAT_DONE;
            case (a)
                psched_pkg::ACT_ATTACH: begin
                    if (psched_pkg::t_mode'(c.job_state) == psched_pkg::MODE_UNINIT) begin
                        r.status = psched_pkg::STAT_IGNORED;
                    end else begin
                        mode_of[id] = psched_pkg::t_mode'(c.job_state);
                        prio_of[id] = clip_prio(c.job_priority);
                        period_of[id] = c.job_period;
                        delay_of[id] = c.start_delay;
                        if (!attached[id]) begin
                            attached[id] = 1;
                            total++;
                        end
                        relink(id);
                    end
                end
                psched_pkg::ACT_STOP, psched_pkg::ACT_SUSPEND,
                psched_pkg::ACT_ACTIVATE, psched_pkg::ACT_SET_PRIO: begin
                    if (!attached[id]) begin
                        r.status = psched_pkg::STAT_IGNORED;
                    end else if (a == psched_pkg::ACT_STOP) begin
                        unlink(id);
                        attached[id] = 0;
                        if (total > 0) total--;
                    end else begin
                        if (a == psched_pkg::ACT_SUSPEND)
                            mode_of[id] = psched_pkg::MODE_SUSPENDED;
                        else if (a == psched_pkg::ACT_ACTIVATE)
                            mode_of[id] = psched_pkg::MODE_ACTIVE;
                        else
                            prio_of[id] = clip_prio(c.job_priority);
                        relink(id);
                    end
                end
                psched_pkg::ACT_RUN: begin
                    r.status = psched_pkg::STAT_EMPTY;
                    for (int p = psched_pkg::NUM_PRIORITIES - 1; p >= 0; p--) begin
                        if (r.dispatch_valid == 0 && ready_q[p].size() > 0) begin
                            j = ready_q[p].pop_front();
                            r.dispatched_job = j;
                            r.dispatch_valid = 1;
                            r.status = psched_pkg::STAT_DONE;
                            dispatches++;
                            if (period_of[j] == 0) begin
                                mode_of[j] = psched_pkg::MODE_SUSPENDED;
                            end else begin
                                delay_of[j] = period_of[j];
                                mode_of[j] = psched_pkg::MODE_SLEEPING;
                                sleep_q.push_back(j);
                            end
                        end
                    end
                end
                psched_pkg::ACT_TICK: begin
                    // Wake expired sleepers in list order, count down the rest
                    foreach (sleep_q[k]) begin
                        j = sleep_q[k];
                        if (delay_of[j] == 0) begin
                            mode_of[j] = psched_pkg::MODE_ACTIVE;
                            ready_q[prio_of[j]].push_back(j);
                        end else begin
                            delay_of[j]--;
                            kept.push_back(j);
                        end
                    end
                    sleep_q = kept;
                end
                default: ;
            endcase
            r.job_count = 5'(total);
            pending.push_back(r);
        endfunction

        function void report(string what, int got, int want);
            $display("mismatch: %s got %0d expected %0d", what, got, want);
            errors++;
        endfunction

        // Compare one response with the oldest expectation
        function void check_result(psched_pkg::t_result got);
            psched_pkg::t_result want;
            checked++;
            if (pending.size() == 0) begin
                report("unexpected response, status", got.status, -1);
                return;
            end
            want = pending.pop_front();
            if (got.dispatched_job !== want.dispatched_job)
                report("dispatched_job", got.dispatched_job, want.dispatched_job);
            if (got.dispatch_valid !== want.dispatch_valid)
                report("dispatch_valid", got.dispatch_valid, want.dispatch_valid);
            if (got.job_count !== want.job_count)
                report("job_count", got.job_count, want.job_count);
            if (got.status !== want.status)
                report("status", got.status, want.status);
        endfunction
    endclass

    localparam int CMD_W = $bits(psched_pkg::t_cmd);

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    psched_pkg::t_cmd    i_cmd;
    logic                busy;
    logic                o_done;
    psched_pkg::t_result o_result;

    sched_scoreboard sb;
    int idle_pct;
    int sent;

    priority_job_scheduler i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Check every response at the edge that ends its cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_result(o_result);
    end

    // Hold a command until accepted, with an optional idle gap first
    task automatic issue(psched_pkg::t_cmd c);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        sb.note_item(c);
        sent++;
    endtask

    task automatic issue_f(psched_pkg::t_action a, int id, int pr, psched_pkg::t_mode m,
                           int per, int dly);
        psched_pkg::t_cmd c;
        c.action = a;
        c.job_id = 4'(id);
        c.job_priority = 8'(pr);
        c.job_state = m;
        c.job_period = 16'(per);
        c.start_delay = 16'(dly);
        issue(c);
    endtask

    // Mostly well-formed scheduling traffic with small periods
    task automatic random_item();
        psched_pkg::t_cmd c;
        int pick;
        c = psched_pkg::t_cmd'(CMD_W'({$urandom, $urandom}));
        pick = $urandom_range(99);
        if (pick < 22) c.action = psched_pkg::ACT_ATTACH;
        else if (pick < 47) c.action = psched_pkg::ACT_RUN;
        else if (pick < 72) c.action = psched_pkg::ACT_TICK;
        else if (pick < 78) c.action = psched_pkg::ACT_STOP;
        else if (pick < 84) c.action = psched_pkg::ACT_SUSPEND;
        else if (pick < 90) c.action = psched_pkg::ACT_ACTIVATE;
        else if (pick < 96) c.action = psched_pkg::ACT_SET_PRIO;
        else c.action = psched_pkg::ACT_QUERY;
        if ($urandom_range(9) < 7) c.job_priority = 8'($urandom_range(3));
        if ($urandom_range(19) != 0) begin
            c.job_period = 16'($urandom_range(6));
            c.start_delay = 16'($urandom_range(6));
        end
        if ($urandom_range(9) != 0 && c.job_state == psched_pkg::MODE_UNINIT)
            c.job_state = 2'($urandom_range(3, 1));
        issue(c);
    endtask

    initial begin
        sb = new();
        sent = 0;
        idle_pct = 0;
        start = 1'b0;
        i_cmd = '0;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty scheduler, field extremes, every command
        issue_f(psched_pkg::ACT_RUN, 0, 0, psched_pkg::MODE_UNINIT, 0, 0);
        issue_f(psched_pkg::ACT_TICK, 0, 0, psched_pkg::MODE_UNINIT, 0, 0);
        issue_f(psched_pkg::ACT_QUERY, 15, 0, psched_pkg::MODE_UNINIT, 0, 0);
        issue_f(psched_pkg::ACT_STOP, 3, 0, psched_pkg::MODE_UNINIT, 0, 0);
        issue_f(psched_pkg::ACT_SET_PRIO, 4, 2, psched_pkg::MODE_UNINIT, 0, 0);
        issue_f(psched_pkg::ACT_ATTACH, 5, 1, psched_pkg::MODE_UNINIT, 1, 1);
        issue_f(psched_pkg::ACT_ATTACH, 0, -128, psched_pkg::MODE_ACTIVE, 0, 0);
        issue_f(psched_pkg::ACT_ATTACH, 15, 127, psched_pkg::MODE_ACTIVE, 65535, 65535);
        issue_f(psched_pkg::ACT_ATTACH, 7, 2, psched_pkg::MODE_SLEEPING, 2, 0);
        issue_f(psched_pkg::ACT_ATTACH, 9, 1, psched_pkg::MODE_SUSPENDED, 3, 1);
        issue_f(psched_pkg::ACT_ATTACH, 7, 3, psched_pkg::MODE_SLEEPING, 1, 1);
        issue_f(psched_pkg::ACT_RUN, 0, 0, psched_pkg::MODE_UNINIT, 0, 0);
        issue_f(psched_pkg::ACT_RUN, 0, 0, psched_pkg::MODE_UNINIT, 0, 0);
        issue_f(psched_pkg::ACT_TICK, 0, 0, psched_pkg::MODE_UNINIT, 0, 0);
        issue_f(psched_pkg::ACT_TICK, 0, 0, psched_pkg::MODE_UNINIT, 0, 0);
        issue_f(psched_pkg::ACT_ACTIVATE, 9, 0, psched_pkg::MODE_UNINIT, 0, 0);
        issue_f(psched_pkg::ACT_SET_PRIO, 9, 100, psched_pkg::MODE_UNINIT, 0, 0);
        issue_f(psched_pkg::ACT_SUSPEND, 15, 0, psched_pkg::MODE_UNINIT, 0, 0);
        issue_f(psched_pkg::ACT_RUN, 0, 0, psched_pkg::MODE_UNINIT, 0, 0);
        issue_f(psched_pkg::ACT_RUN, 0, 0, psched_pkg::MODE_UNINIT, 0, 0);
        issue_f(psched_pkg::ACT_STOP, 15, 0, psched_pkg::MODE_UNINIT, 0, 0);
        issue_f(psched_pkg::ACT_STOP, 15, 0, psched_pkg::MODE_UNINIT, 0, 0);
        issue_f(psched_pkg::ACT_QUERY, 0, 0, psched_pkg::MODE_UNINIT, 0, 0);

        // Random traffic in four phases, two of them with idle gaps
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1) ? 45 : (ph == 3) ? 18 : 0;
            repeat (310) random_item();
        end
        start <= 1'b0;

        // Drain outstanding responses
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("ran %0d commands, checked %0d responses, %0d dispatches",
                 sent, sb.checked, sb.dispatches);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("** priority_job_scheduler: PASSED **");
        end else begin
            $display("** priority_job_scheduler: FAILED **");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("timeout waiting for the scheduler");
        $display("** priority_job_scheduler: FAILED **");
        $finish;
    end

endmodule
`default_nettype wire
